// ===== hw/rtl/idqp_pkg.sv =====
package idqp_pkg;

   // Phase codes of the parse machine: odd codes sit inside an octet,
   // even nonzero codes sit right after a dot.
   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_OCTET1 = 3'd1;
   localparam logic [2:0] PH_DOT1   = 3'd2;
   localparam logic [2:0] PH_OCTET2 = 3'd3;
   localparam logic [2:0] PH_DOT2   = 3'd4;
   localparam logic [2:0] PH_OCTET3 = 3'd5;
   localparam logic [2:0] PH_DOT3   = 3'd6;
   localparam logic [2:0] PH_OCTET4 = 3'd7;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [11:0] OCTET_MAX  = 12'd255;
   localparam logic [3:0]  DIGIT_BASE = 4'd10;
   localparam int          ADDR_W     = 32;
   localparam int          OUT_CNT_W  = 16;

   typedef enum logic [1:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_BLANK,
      CLS_BAD
   } char_class_type;

   typedef logic [3:0][7:0] octets_type;

   typedef struct packed {
      logic fire;
      logic good;
   } verdict_type;

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type cls;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else if (ch == CHAR_DOT) begin
         cls = CLS_DOT;
      end else if (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_LF || ch == CHAR_CR) begin
         cls = CLS_BLANK;
      end else begin
         cls = CLS_BAD;
      end
      return cls;
   endfunction

endpackage

// ===== hw/rtl/idqp_step.sv =====
module idqp_step
   import idqp_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic [7:0]             in_byte,
   input  logic                   last_byte,
   input  logic [2:0]             phase,
   input  octets_type             octets,
   input  logic [COUNT_WIDTH-1:0] pos,
   input  logic                   decided,
   output logic [2:0]             phase_next,
   output octets_type             octets_next,
   output logic [COUNT_WIDTH-1:0] pos_next,
   output logic                   decided_next,
   output verdict_type            verdict,
   output logic [COUNT_WIDTH-1:0] count
);

   localparam logic [COUNT_WIDTH-1:0] CNT_CAP = '1;

   char_class_type  cls;
   logic [3:0]      digit;
   logic [1:0]      idx;
   logic [11:0]     acc;
   logic            bad;
   logic            done;
   logic [COUNT_WIDTH-1:0] pos_inc;

   assign cls   = classify(in_byte);
   assign digit = 4'(in_byte - CHAR_ZERO);
   assign idx   = phase[2:1];
   assign acc   = 12'(octets[3 - idx]) * 12'(DIGIT_BASE) + 12'(digit);
   assign pos_inc = (pos == CNT_CAP) ? pos : pos + 1'b1;

   always_comb begin
      phase_next   = phase;
      octets_next  = octets;
      bad          = 1'b0;
      done         = 1'b0;
      case (cls)
         CLS_DIGIT: begin
            if (phase == PH_START) begin
               phase_next = PH_OCTET1;
               octets_next[3] = 8'(digit);
            end else if (phase[0]) begin
               if (acc > OCTET_MAX) begin
                  bad = 1'b1;
               end else begin
                  octets_next[3 - idx] = acc[7:0];
               end
            end else begin
               phase_next = phase + 3'd1;
               octets_next[3 - idx] = 8'(digit);
            end
         end
         CLS_DOT: begin
            if (phase == PH_OCTET1 || phase == PH_OCTET2 || phase == PH_OCTET3) begin
               phase_next = phase + 3'd1;
            end else begin
               bad = 1'b1;
            end
         end
         CLS_BLANK: begin
            if (phase == PH_OCTET4) begin
               done = 1'b1;
            end else if (phase != PH_START) begin
               bad = 1'b1;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      verdict      = '0;
      count        = pos;
      pos_next     = pos;
      decided_next = decided;
      if (decided) begin
         // Bytes after a decision are dropped until the end of the buffer.
      end else if (bad) begin
         verdict = '{fire: 1'b1, good: 1'b0};
      end else if (done) begin
         verdict = '{fire: 1'b1, good: 1'b1};
      end else begin
         pos_next = pos_inc;
         count    = pos_inc;
         if (last_byte) begin
            verdict = '{fire: 1'b1, good: (phase_next == PH_OCTET4)};
         end
      end
      if (verdict.fire) begin
         decided_next = 1'b1;
      end
   end

endmodule

// ===== hw/rtl/ipv4_dotted_quad_parser.sv =====
// IPv4 dotted-quad text parser.
// The request channel carries one text byte per transaction in req_tdata,
// with req_tlast high on the final byte of a buffer. The parser skips
// leading blanks, then reads four decimal octets (0..255) separated by dots,
// ended by a blank or by the end of the buffer.
// Exactly one response transaction comes per buffer, in the cycle after the
// byte that decides the parse is taken. rsp_tuser is high for a valid
// address; rsp_tdata then holds the address and the count of bytes before
// the terminating blank (or the buffer length). On an error both are zero.
// Bytes that follow a decision are absorbed without a response until the
// byte with req_tlast, which rearms the parser for the next buffer.
// Throughput is one byte per cycle unless a held response stalls it: the
// per-byte step is one logic pass from parse state to response register.
// The response register holds its transaction while rsp_tready is low; a
// new byte is still taken in the cycle the held response is delivered.
// Reset returns the parser to the start of a buffer with no response pending.
module ipv4_dotted_quad_parser
   import idqp_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] address, [47:32] consumed
   output logic [0:0]  rsp_tuser    // [0] ok
);

   logic [2:0]             phase_ff, phase_in;
   octets_type             octets_ff, octets_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic                   decided_ff, decided_in;

   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff;
   logic [ADDR_W-1:0]      rsp_addr_ff;
   logic [OUT_CNT_W-1:0]   rsp_cnt_ff;

   verdict_type            verdict;
   logic [COUNT_WIDTH-1:0] count;
   logic [32:0]            count_ext;
   logic [OUT_CNT_W-1:0]   count_sat;
   logic                   req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   idqp_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .in_byte      (req_tdata),
      .last_byte    (req_tlast),
      .phase        (phase_ff),
      .octets       (octets_ff),
      .pos          (pos_ff),
      .decided      (decided_ff),
      .phase_next   (phase_in),
      .octets_next  (octets_in),
      .pos_next     (pos_in),
      .decided_next (decided_in),
      .verdict      (verdict),
      .count        (count)
   );

   assign count_ext = 33'(count);
   assign count_sat = (count_ext > 33'(17'h0FFFF)) ? '1 : count_ext[OUT_CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         octets_ff  <= '0;
         pos_ff     <= '0;
         decided_ff <= 1'b0;
      end else if (req_take) begin
         if (req_tlast) begin
            phase_ff   <= PH_START;
            octets_ff  <= '0;
            pos_ff     <= '0;
            decided_ff <= 1'b0;
         end else begin
            phase_ff   <= phase_in;
            octets_ff  <= octets_in;
            pos_ff     <= pos_in;
            decided_ff <= decided_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= verdict.fire;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && verdict.fire) begin
         rsp_ok_ff   <= verdict.good;
         rsp_addr_ff <= verdict.good ? octets_in : '0;
         rsp_cnt_ff  <= verdict.good ? count_sat : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_cnt_ff, rsp_addr_ff};
   assign rsp_tuser[0] = rsp_ok_ff;

`ifndef ASSERT_OFF
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 48'd0)
      else $error("error response carries nonzero data");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[47:32] != 16'd0)
      else $error("valid address with zero byte count");

   a_no_resp_after_decision: assert property (@(posedge clock) disable iff (reset)
      req_take && decided_ff |=> !rsp_tvalid)
      else $error("response produced after the buffer was decided");

   a_resp_from_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_take))
      else $error("response appeared without an accepted byte");
`endif

endmodule
